@@ hw/rtl/sync_length_frame_receiver_top_macros.svh @@
`ifndef SYNC_LENGTH_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slfr assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SLFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slfr assertion failed");

`endif

@@ hw/rtl/slfr_pkg.sv @@
`timescale 1ns / 1ps

package slfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    // Frame buffers and queued frame descriptors
    localparam int FIFO_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [5:0] MAX_LENGTH_RST  = 6'd19;

endpackage

@@ hw/rtl/slfr_fifo.sv @@
`timescale 1ns / 1ps

module slfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = slfr_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/slfr_front.sv @@
`timescale 1ns / 1ps

module slfr_front #(
    parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
    parameter int IDX_W = $clog2(MAX_PAYLOAD),
    parameter int LEN_W = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [slfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    input  logic                             q_full,
    output logic                             wr_en,
    output logic [IDX_W:0]                   wr_addr,
    output logic [7:0]                       wr_data,
    output logic                             q_push,
    output logic [LEN_W:0]                   q_push_data
);

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             bank_reg;
    logic             bank_next;
    logic [7:0]       sync_first_reg;
    logic [7:0]       sync_second_reg;
    logic [5:0]       max_length_reg;

    logic             accept;
    logic             len_ok;
    logic             frame_done;

    assign in_ready   = !((phase_reg == PH_DATA) && q_full);
    assign accept     = in_valid && in_ready;
    assign len_ok     = (rx_byte != 8'd0)
                        && (rx_byte <= {2'b00, max_length_reg})
                        && (rx_byte <= 8'(MAX_PAYLOAD));
    assign frame_done = (LEN_W'(count_reg) + 1'b1 == len_reg);

    assign wr_en       = accept && (phase_reg == PH_DATA);
    assign wr_addr     = {bank_reg, count_reg};
    assign wr_data     = rx_byte;
    assign q_push      = wr_en && frame_done;
    assign q_push_data = {bank_reg, len_reg};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == sync_first_reg)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (rx_byte == sync_second_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                    else if (rx_byte != sync_first_reg)
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LEN:
                begin
                    if (len_ok)
                    begin
                        phase_next = PH_DATA;
                        count_next = '0;
                        len_next   = LEN_W'(rx_byte);
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_DATA:
                begin
                    if (frame_done)
                    begin
                        phase_next = PH_SYNC1;
                        bank_next  = !bank_reg;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC1;
            count_reg       <= '0;
            len_reg         <= '0;
            bank_reg        <= 1'b0;
            sync_first_reg  <= slfr_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slfr_pkg::SYNC_SECOND_RST;
            max_length_reg  <= slfr_pkg::MAX_LENGTH_RST;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            bank_reg  <= bank_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    slfr_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    slfr_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    slfr_pkg::CFG_MAX_LENGTH:  max_length_reg  <= cfg_data[5:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/slfr_back.sv @@
`timescale 1ns / 1ps

module slfr_back #(
    parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
    parameter int IDX_W = $clog2(MAX_PAYLOAD),
    parameter int LEN_W = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W:0]   wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             q_empty,
    input  logic [LEN_W:0]   q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       payload_byte,
    output logic [4:0]       byte_index,
    output logic [5:0]       frame_length,
    output logic             last_byte
);

    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

    // Two frame banks, selected by the top address bit
    logic [7:0]       store_reg [MEM_DEPTH];
    logic [7:0]       rd_data_reg;

    logic [IDX_W-1:0] rd_idx_reg;
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_last_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [4:0]       out_idx_reg;
    logic [5:0]       out_len_reg;
    logic             out_last_reg;

    logic             head_bank;
    logic [LEN_W-1:0] head_len;
    logic             adv;
    logic             s1_go;
    logic             issue;
    logic             rd_last;

    assign head_bank = q_head[LEN_W];
    assign head_len  = q_head[LEN_W-1:0];
    assign adv       = !out_valid_reg || out_ready;
    assign s1_go     = s1_valid_reg && adv;
    assign issue     = !q_empty && (!s1_valid_reg || adv);
    assign rd_last   = (LEN_W'(rd_idx_reg) + 1'b1 == head_len);
    assign q_pop     = issue && rd_last;

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign byte_index   = out_idx_reg;
    assign frame_length = out_len_reg;
    assign last_byte    = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= store_reg[{head_bank, rd_idx_reg}];
            s1_idx_reg  <= rd_idx_reg;
            s1_len_reg  <= head_len;
            s1_last_reg <= rd_last;
        end
        if (s1_go)
        begin
            out_byte_reg <= rd_data_reg;
            out_idx_reg  <= 5'(s1_idx_reg);
            out_len_reg  <= 6'(s1_len_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
                rd_idx_reg   <= rd_last ? '0 : rd_idx_reg + 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/sync_length_frame_receiver_top.sv @@
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    rx_byte
// out       out_valid / out_ready  payload_byte, byte_index, frame_length, last_byte
// cfg       cfg_write              cfg_index, cfg_data
//
// One byte per cycle in while in_ready is high. A frame leaves byte by byte once its
// last payload byte is taken: frame store write, memory read register, output register.
// Two frame banks: in_ready drops in the payload phase only while two finished frames
// are queued and not yet read from the store. Reset restores the config defaults; no clearing pass.

module sync_length_frame_receiver_top #(
    parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [slfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       payload_byte,
    output logic [4:0]                       byte_index,
    output logic [5:0]                       frame_length,
    output logic                             last_byte
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    logic             wr_en;
    logic [IDX_W:0]   wr_addr;
    logic [7:0]       wr_data;
    logic             q_push;
    logic [LEN_W:0]   q_push_data;
    logic             q_pop;
    logic [LEN_W:0]   q_head;
    logic             q_empty;
    logic             q_full;

    slfr_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .IDX_W(IDX_W),
        .LEN_W(LEN_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .q_full(q_full),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .q_push(q_push),
        .q_push_data(q_push_data)
    );

    slfr_fifo #(
        .WIDTH(LEN_W + 1),
        .DEPTH(slfr_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data(q_push_data),
        .pop(q_pop),
        .head_data(q_head),
        .empty(q_empty),
        .full(q_full)
    );

    slfr_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .IDX_W(IDX_W),
        .LEN_W(LEN_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .q_empty(q_empty),
        .q_head(q_head),
        .q_pop(q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .payload_byte(payload_byte),
        .byte_index(byte_index),
        .frame_length(frame_length),
        .last_byte(last_byte)
    );

`include "sync_length_frame_receiver_top_macros.svh"

    `SLFR_ASSERT_NOW(a_push_not_full, q_push, !q_full)
    `SLFR_ASSERT_NOW(a_stall_only_full, !in_ready, q_full)
    `SLFR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)
    `SLFR_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty)

endmodule
